// ===== hdl/sha256_stream_hasher_unit_assert.svh =====
// Assertion macros for the SHA-256 stream hasher
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
// implication checked every cycle outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/sha_pkg.sv =====
// Package: SHA-256 constants, types and round functions
package sha_pkg;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic [1:0] {
        T_PAD_NONE,
        T_PAD_FINAL,
        T_PAD_EXTRA
    } t_pad;

    typedef struct packed {
        logic        fin;
        logic [7:0]  data;
    } t_qitem;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_bstate;

    typedef logic [31:0] t_word;

    localparam t_word H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
        32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
        32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
        32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
        32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
        32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ===== hdl/sha256_stream_hasher_unit.sv =====
// Top level: SHA-256 stream hasher, byte input, digest word output
// Usage:
//   Input channel (i_valid/o_ready) carries one item per handshake: a
//   message byte (i_kind 0) or a finish request (i_kind 1).
//   Items enter a four-deep queue, so the sender keeps going while the
//   compression engine works.
//   A data byte goes into the block buffer; every 64th byte starts a
//   block compression that loads the schedule words, runs the rounds
//   and adds the result into the hash. The single shared round unit
//   sets the throughput: no bytes leave the queue while it is in use.
//   A finish item runs one or two compressions (two when 56 or more
//   bytes remain in the buffer) then presents eight digest words on
//   o_valid/i_ready, word 0 first, o_last_word on word 7.
//   A stalled receiver holds the current word; the queue keeps filling
//   and then drops o_ready.
//   After word 7 the hash restarts at the initial value.
//   Reset (i_rst_n low, synchronous) empties the queue and loads the
//   initial hash value; no clearing pass is needed.
module sha256_stream_hasher_unit import sha_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
`include "sha256_stream_hasher_unit_assert.svh"
    logic   full, empty, pop, busy;
    t_qitem qin, qout;

    assign qin = '{fin: i_kind, data: i_data_byte};
    assign o_ready = !full;

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_valid), .i_item(qin),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_item(qout)
    );

    sha_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_item(qout), .o_pop(pop),
        .o_valid(o_valid), .i_ready(i_ready), .o_digest_word(o_digest_word),
        .o_word_index(o_word_index), .o_last_word(o_last_word), .o_busy(busy)
    );

    `SHA_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, pop, !empty)
    `SHA_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy && !pop)
    `SHA_ASSERT_NEXT(a_word_step, i_clk, i_rst_n, o_valid && i_ready && !o_last_word,
        o_valid && o_word_index == $past(o_word_index) + 3'd1)
endmodule

// ===== hdl/sha_queue.sv =====
// Small FIFO between the byte front end and the compression engine
module sha_queue import sha_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qitem i_item,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_qitem o_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_qitem r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push && !o_full)
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop && !o_empty)
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

// ===== hdl/sha_engine.sv =====
// Back end: block buffer, padding, 64-round compression and digest output
module sha_engine import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_qitem      i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_busy
);
    // block buffer kept as 16 big-endian words, written one byte lane at a time
    t_word       r_blk [16];
    logic [5:0]  r_fill;
    logic [60:0] r_bytes;
    t_word       r_h [8];
    t_word       r_v [8];
    t_word       r_w [16];
    t_bstate     r_st, n_st;
    t_pad        r_pad;
    logic [5:0]  r_rnd;
    logic [3:0]  r_ld;
    logic [2:0]  r_oi;

    // pad byte at position p of the current final block
    function automatic logic [7:0] pad_byte(input logic [5:0] p, input t_pad pd,
                                            input logic [63:0] bits,
                                            input logic [7:0] stored);
        logic [7:0] b;
        if (pd == T_PAD_NONE) b = stored;
        else if (pd == T_PAD_EXTRA) b = 8'h00;
        else if (p >= 6'd56) b = bits[8*(63-p) +: 8];
        else b = 8'h00;
        pad_byte = b;
    endfunction

    // r_mark holds where 0x80 goes, r_mark_on whether it is in this block
    logic       r_mark_on;
    logic [5:0] r_mark;
    logic [63:0] bits;
    assign bits = {r_bytes, 3'b000};

    logic [7:0] ld_b [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [5:0] p;
            p = {r_ld, 2'(k)};
            if (r_pad == T_PAD_NONE || p < r_fill) ld_b[k] = r_blk[r_ld][8*(3-k) +: 8];
            else ld_b[k] = 8'h00;
            if (r_pad != T_PAD_NONE && r_mark_on && p == r_mark) ld_b[k] = 8'h80;
            else if (r_pad == T_PAD_FINAL && p >= 6'd56)
                ld_b[k] = pad_byte(p, r_pad, bits, 8'h00);
            else if (r_pad != T_PAD_NONE && !(p < r_fill && r_mark_on)) ld_b[k] = 8'h00;
        end
    end

    t_word w15, w2, wn, wr, t1, t2, a, e;
    always_comb begin
        w15 = r_w[1]; w2 = r_w[14];
        wn = r_w[0] + (rotr(w15,7) ^ rotr(w15,18) ^ (w15 >> 3)) + r_w[9]
           + (rotr(w2,17) ^ rotr(w2,19) ^ (w2 >> 10));
        wr = r_w[0];
        a = r_v[0]; e = r_v[4];
        t1 = r_v[7] + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & r_v[5]) ^ (~e & r_v[6]))
           + K[r_rnd] + wr;
        t2 = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) ^ 32'h0;
        t2 = t2 + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign o_valid = (r_st == S_EMIT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 3'd7);
    assign o_busy = (r_st != S_IDLE);

    always_comb begin
        n_st = r_st;
        o_pop = 1'b0;
        case (r_st)
            S_IDLE: if (!i_empty) begin
                o_pop = 1'b1;
                if (i_item.fin || r_fill == 6'd63) n_st = S_LOAD;
            end
            S_LOAD:  if (r_ld == 4'd15) n_st = S_ROUND;
            S_ROUND: if (r_rnd == 6'd63) n_st = S_ADD;
            S_ADD: begin
                if (r_pad == T_PAD_EXTRA) n_st = S_LOAD;
                else if (r_pad == T_PAD_FINAL) n_st = S_EMIT;
                else n_st = S_IDLE;
            end
            S_EMIT: if (i_ready && r_oi == 3'd7) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && !i_empty && !i_item.fin)
            r_blk[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_item.data;
        if (r_st == S_LOAD) begin
            r_w[r_ld] <= {ld_b[0], ld_b[1], ld_b[2], ld_b[3]};
            if (r_ld == 4'd15) for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
        end
        if (r_st == S_ROUND) begin
            for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
            r_w[15] <= wn;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4]; r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0]; r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fill <= '0; r_bytes <= '0; r_pad <= T_PAD_NONE;
            r_rnd <= '0; r_ld <= '0; r_oi <= '0; r_mark_on <= 1'b0; r_mark <= '0;
            for (int j = 0; j < 8; j++) r_h[j] <= H0[j];
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: if (!i_empty) begin
                    r_ld <= '0;
                    if (i_item.fin) begin
                        r_mark <= r_fill; r_mark_on <= 1'b1;
                        r_pad <= (r_fill > 6'd55) ? T_PAD_EXTRA : T_PAD_FINAL;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                        r_bytes <= r_bytes + 1'b1;
                        r_pad <= T_PAD_NONE;
                    end
                end
                S_LOAD: begin
                    r_ld <= r_ld + 1'b1;
                    r_rnd <= '0;
                end
                S_ROUND: r_rnd <= r_rnd + 1'b1;
                S_ADD: begin
                    for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
                    r_ld <= '0;
                    if (r_pad == T_PAD_EXTRA) begin
                        // second block: only zeros and the length
                        r_pad <= T_PAD_FINAL; r_mark_on <= 1'b0; r_fill <= '0;
                    end
                    r_oi <= '0;
                end
                S_EMIT: if (i_ready) begin
                    r_oi <= r_oi + 1'b1;
                    if (r_oi == 3'd7) begin
                        for (int j = 0; j < 8; j++) r_h[j] <= H0[j];
                        r_fill <= '0; r_bytes <= '0; r_pad <= T_PAD_NONE;
                        r_mark_on <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the SHA-256 stream hasher: byte stream in, checked digest words out
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_out;

    class digest_board;
        t_word       hv [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [60:0] nbytes;
        t_digest_out pending [$];
        int          errors;
        int          words_checked;

        function void restart();
            for (int i = 0; i < 8; i++) hv[i] = H0[i];
            fill = 0;
            nbytes = '0;
        endfunction

        function t_word rr(t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            t_word w [64];
            t_word v [8];
            t_word t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
                       + w[i-7] + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
            v = hv;
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[i] + w[i];
                t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hv[i] += v[i];
        endfunction

        function void note_item(logic kind, logic [7:0] data);
            logic [63:0] bits;
            int unsigned p;
            t_digest_out d;
            if (kind == KIND_DATA) begin
                blk[fill] = data;
                fill = (fill + 1) % 64;
                nbytes = nbytes + 1;
                if (fill == 0) compress();
                return;
            end
            bits = {nbytes, 3'b000};
            p = fill;
            blk[p++] = 8'h80;
            if (p > 56) begin
                while (p < 64) blk[p++] = 8'h00;
                compress();
                p = 0;
            end
            while (p < 56) blk[p++] = 8'h00;
            for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                d.word = hv[i];
                d.index = 3'(i);
                d.last = (i == 7);
                pending.push_back(d);
            end
            restart();
        endfunction

        function void check_word(t_word word, logic [2:0] index, logic last);
            t_digest_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time, word, index);
                errors++;
                return;
            end
            e = pending.pop_front();
            words_checked++;
            if (word !== e.word || index !== e.index || last !== e.last) begin
                $display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b",
                         $time, e.word, e.index, e.last, word, index, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_kind = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_last_word;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;

    digest_board board = new();
    int    cycles;
    int    items_sent;
    int    messages;
    bit    stall_long;
    bit    drained;
    bit    no_gaps;

    sha256_stream_hasher_unit i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_data_byte,
        .o_valid, .i_ready, .o_digest_word, .o_word_index, .o_last_word
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        if (no_gaps) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // hold valid until the handshake, then note the item
    task automatic send_item(logic kind, logic [7:0] data);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        board.note_item(kind, data);
        items_sent++;
        if (kind == KIND_FINISH) messages++;
    endtask

    task automatic send_message(int len, int mode);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: send_item(KIND_DATA, 8'($urandom));
                1: send_item(KIND_DATA, 8'h00);
                default: send_item(KIND_DATA, 8'hff);
            endcase
        end
        send_item(KIND_FINISH, 8'($urandom));
    endtask

    // receiver: checks each accepted word; random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_word(o_digest_word, o_word_index, o_last_word);
    end

    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            if (stall_long) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                stall_long = 1'b0;
            end
            hold = gap_len();
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int len;
        board.restart();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty message, padding boundaries, extreme byte values
        send_message(0, 0);
        send_message(3, 0);
        send_message(5, 1);
        send_message(5, 2);
        send_item(KIND_DATA, 8'h55);
        send_item(KIND_FINISH, 8'hff);
        send_message(55, 0);
        send_message(56, 0);
        send_message(64, 0);
        // drive the queue full while the receiver holds off
        stall_long = 1'b1;
        no_gaps = 1'b1;
        send_message(2, 0);
        send_message(1, 0);
        send_message(0, 0);
        no_gaps = 1'b0;
        // random: mostly short messages, a few across block boundaries
        while (items_sent < 255) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130)
                                              : $urandom_range(0, 12);
            if (len > 255 - items_sent) len = 255 - items_sent;
            no_gaps = ($urandom_range(0, 4) == 0);
            send_message(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
        end
        no_gaps = 1'b0;
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d items in %0d messages, checked %0d digest words",
                 items_sent, messages, board.words_checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
